// ----- hdl/evag_pkg.sv -----
`default_nettype none

package evag_pkg;

    // default widths and depths
    localparam int COUNT_WIDTH_DEF = 24;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int CMP_WIDTH       = 32;

    // fixed field widths
    localparam int SAMPLE_WIDTH  = 8;
    localparam int PKT_WIDTH     = 13;
    localparam int LIMIT_WIDTH   = 24;
    localparam int REQ_NUM_WIDTH = 16;
    localparam int CFG_IDX_WIDTH = 3;

    localparam logic [PKT_WIDTH-1:0] PKT_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_QUIET_LEVEL    = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_LOUD_MINIMUM   = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SPEECH_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SILENCE_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MINIMUM_LENGTH = 3'd4;

    // configuration reset values
    localparam logic [7:0]             QUIET_LEVEL_RST    = 8'd10;
    localparam logic [PKT_WIDTH-1:0]   LOUD_MINIMUM_RST   = 13'd50;
    localparam logic [LIMIT_WIDTH-1:0] SPEECH_LIMIT_RST   = 24'd48000;
    localparam logic [LIMIT_WIDTH-1:0] SILENCE_LIMIT_RST  = 24'd96000;
    localparam logic [LIMIT_WIDTH-1:0] MINIMUM_LENGTH_RST = 24'd72000;

    typedef enum logic [1:0] {
        DEC_NONE      = 2'd0,
        DEC_REQUEST   = 2'd1,
        DEC_TOO_SHORT = 2'd2
    } decision_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_byte;
        logic                           last_in_packet;
        logic                           playback_active;
    } sample_t;

    typedef struct packed {
        logic                      keep_packet;
        decision_t                 decision;
        logic [REQ_NUM_WIDTH-1:0]  request_number;
        logic [LIMIT_WIDTH-1:0]    request_length;
    } result_t;

    // per-packet summary handed from front to back
    typedef struct packed {
        logic [PKT_WIDTH-1:0] quiet_count;
        logic [PKT_WIDTH-1:0] loud_count;
    } pkt_sum_t;

    // settings used by the packet-end unit
    typedef struct packed {
        logic [PKT_WIDTH-1:0]   packet_loud_minimum;
        logic [LIMIT_WIDTH-1:0] speech_limit;
        logic [LIMIT_WIDTH-1:0] silence_limit;
        logic [LIMIT_WIDTH-1:0] minimum_length;
    } back_cfg_t;

endpackage

`default_nettype wire

// ----- hdl/evag_stream_if.sv -----
`default_nettype none

interface evag_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hdl/evag_front.sv -----
`default_nettype none

module evag_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [7:0]           quiet_level,
    evag_stream_if.sink               sample,
    input  wire logic                 queue_full,
    output logic                      push,
    output evag_pkg::pkt_sum_t        push_data
);

    logic [evag_pkg::PKT_WIDTH-1:0] quiet_reg, quiet_next;
    logic [evag_pkg::PKT_WIDTH-1:0] loud_reg, loud_next;
    logic [7:0]                     mag;
    logic                           is_quiet;
    logic                           accept;

    assign sample.ready = !queue_full;
    assign accept       = sample.valid && !queue_full;

    // -128 maps to 128, which still fits in 8 bits
    assign mag      = sample.payload.sample_byte[7] ? 8'(-sample.payload.sample_byte)
                                                    : 8'(sample.payload.sample_byte);
    assign is_quiet = mag < quiet_level;

    always_comb
    begin
        quiet_next = quiet_reg;
        loud_next  = loud_reg;
        if (is_quiet)
        begin
            if (quiet_reg != evag_pkg::PKT_MAX)
                quiet_next = quiet_reg + evag_pkg::PKT_WIDTH'(1);
        end
        else
        begin
            if (loud_reg != evag_pkg::PKT_MAX)
                loud_next = loud_reg + evag_pkg::PKT_WIDTH'(1);
        end
    end

    // packets ending during playback never reach the queue
    assign push = accept && sample.payload.last_in_packet && !sample.payload.playback_active;
    assign push_data.quiet_count = quiet_next;
    assign push_data.loud_count  = loud_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_reg <= '0;
            loud_reg  <= '0;
        end
        else if (accept)
        begin
            if (sample.payload.last_in_packet)
            begin
                quiet_reg <= '0;
                loud_reg  <= '0;
            end
            else
            begin
                quiet_reg <= quiet_next;
                loud_reg  <= loud_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/evag_queue.sv -----
`default_nettype none

module evag_queue #(
    parameter int DEPTH = evag_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire evag_pkg::pkt_sum_t push_data,
    input  wire logic               pop,
    output evag_pkg::pkt_sum_t      pop_data,
    output logic                    full,
    output logic                    empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    evag_pkg::pkt_sum_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |=> !(count_reg == '0) && (count_reg <= CNT_W'(DEPTH)))
        else $error("summary queue count out of range");

endmodule

`default_nettype wire

// ----- hdl/evag_back.sv -----
`default_nettype none

module evag_back #(
    parameter int COUNT_WIDTH = evag_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire evag_pkg::back_cfg_t  cfg,
    input  wire logic                 queue_empty,
    input  wire evag_pkg::pkt_sum_t   pop_data,
    output logic                      pop,
    evag_stream_if.source             result
);

    localparam int W  = COUNT_WIDTH;
    localparam int CW = evag_pkg::CMP_WIDTH;
    localparam int LW = evag_pkg::LIMIT_WIDTH;

    logic [W-1:0]  lt_reg, lt_next;
    logic [W-1:0]  st_reg, st_next;
    logic [W-1:0]  kl_reg, kl_next;
    logic          brk_reg, brk_next;
    logic          sp_reg, sp_next;
    logic [evag_pkg::REQ_NUM_WIDTH-1:0] rc_reg, rc_next;

    logic                 out_valid_reg;
    evag_pkg::result_t    out_reg, out_next;

    logic [W:0]    lt_sum, st_sum, kl_sum;
    logic [W-1:0]  lt_sat, st_sat, kl_sat;
    logic          keep;

    assign pop = !queue_empty && (!out_valid_reg || result.ready);

    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    // saturating adds run in parallel, only one of loud/silence is used
    assign lt_sum = {1'b0, lt_reg} + (W+1)'(pop_data.loud_count);
    assign st_sum = {1'b0, st_reg} + (W+1)'(pop_data.quiet_count);
    assign kl_sum = {1'b0, kl_reg} + (W+1)'(pop_data.loud_count)
                                   + (W+1)'(pop_data.quiet_count);
    assign lt_sat = lt_sum[W] ? '1 : lt_sum[W-1:0];
    assign st_sat = st_sum[W] ? '1 : st_sum[W-1:0];
    assign kl_sat = kl_sum[W] ? '1 : kl_sum[W-1:0];

    assign keep = pop_data.loud_count > cfg.packet_loud_minimum;

    always_comb
    begin
        lt_next  = lt_reg;
        st_next  = st_reg;
        kl_next  = kl_reg;
        brk_next = brk_reg;
        sp_next  = sp_reg;
        rc_next  = rc_reg;
        out_next.keep_packet    = keep;
        out_next.decision       = evag_pkg::DEC_NONE;
        out_next.request_number = '0;
        out_next.request_length = '0;

        if (keep)
        begin
            lt_next  = lt_sat;
            brk_next = 1'b0;
            kl_next  = kl_sat;
            if (CW'(lt_sat) > CW'(cfg.speech_limit))
            begin
                st_next = '0;
                sp_next = 1'b1;
            end
        end
        else
        begin
            st_next = st_sat;
            if (CW'(st_sat) > CW'(cfg.silence_limit))
            begin
                lt_next  = '0;
                brk_next = 1'b1;
            end
        end

        if (brk_next && sp_next)
        begin
            brk_next = 1'b0;
            lt_next  = '0;
            st_next  = '0;
            if (CW'(kl_next) < CW'(cfg.minimum_length))
            begin
                out_next.decision = evag_pkg::DEC_TOO_SHORT;
            end
            else
            begin
                out_next.decision       = evag_pkg::DEC_REQUEST;
                out_next.request_number = rc_reg;
                out_next.request_length = LW'(CW'(kl_next));
                rc_next = rc_reg + evag_pkg::REQ_NUM_WIDTH'(1);
                kl_next = '0;
                sp_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg        <= '0;
            st_reg        <= '0;
            kl_reg        <= '0;
            brk_reg       <= 1'b0;
            sp_reg        <= 1'b0;
            rc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                lt_reg  <= lt_next;
                st_reg  <= st_next;
                kl_reg  <= kl_next;
                brk_reg <= brk_next;
                sp_reg  <= sp_next;
                rc_reg  <= rc_next;
            end
            if (pop)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_reg <= out_next;
    end

    a_flags_resolved: assert property (@(posedge clk) disable iff (!rst_n)
        !(brk_reg && sp_reg))
        else $error("break and speech both pending after update");

    a_req_count: assert property (@(posedge clk) disable iff (!rst_n)
        pop && (out_next.decision == evag_pkg::DEC_REQUEST)
        |=> rc_reg == 16'($past(rc_reg) + 16'd1))
        else $error("request number did not advance");

    a_req_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.decision != evag_pkg::DEC_REQUEST)
        |-> (out_reg.request_number == '0) && (out_reg.request_length == '0))
        else $error("request fields set without a request");

endmodule

`default_nettype wire

// ----- hdl/energy_voice_activity_gate.sv -----
// channel  | dir | beat payload                                       | role
// ---------+-----+----------------------------------------------------+---------------------
// sample   | in  | sample_byte, last_in_packet, playback_active       | one audio byte
// result   | out | keep_packet, decision, request_number, request_len | per queued packet
// cfg_*    | in  | cfg_write_en, cfg_index, cfg_data                  | register writes
//
// one sample beat per cycle while the summary queue is not full
// the summary enters the queue at the edge that takes the last beat; the back unit pops
// it once its output register is free, registering the update and the result beat
// a queue of QUEUE_DEPTH packet summaries lets the front keep taking bytes
// while a result waits; sample.ready drops only when that queue is full
// reset clears all counters, flags and the queue and loads register defaults
`default_nettype none

module energy_voice_activity_gate #(
    parameter int COUNT_WIDTH = evag_pkg::COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = evag_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write_en,
    input  wire logic [evag_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  wire logic [evag_pkg::LIMIT_WIDTH-1:0]    cfg_data,
    evag_stream_if.sink                              sample,
    evag_stream_if.source                            result
);

    // configuration registers
    logic [7:0]                       quiet_level_reg;
    logic [evag_pkg::PKT_WIDTH-1:0]   loud_minimum_reg;
    logic [evag_pkg::LIMIT_WIDTH-1:0] speech_limit_reg;
    logic [evag_pkg::LIMIT_WIDTH-1:0] silence_limit_reg;
    logic [evag_pkg::LIMIT_WIDTH-1:0] minimum_length_reg;

    evag_pkg::back_cfg_t back_cfg;

    // front to queue to back
    logic               push;
    evag_pkg::pkt_sum_t push_data;
    logic               pop;
    evag_pkg::pkt_sum_t pop_data;
    logic               queue_full;
    logic               queue_empty;

    // writes to unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_level_reg    <= evag_pkg::QUIET_LEVEL_RST;
            loud_minimum_reg   <= evag_pkg::LOUD_MINIMUM_RST;
            speech_limit_reg   <= evag_pkg::SPEECH_LIMIT_RST;
            silence_limit_reg  <= evag_pkg::SILENCE_LIMIT_RST;
            minimum_length_reg <= evag_pkg::MINIMUM_LENGTH_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                evag_pkg::REG_QUIET_LEVEL:    quiet_level_reg    <= cfg_data[7:0];
                evag_pkg::REG_LOUD_MINIMUM:   loud_minimum_reg   <= cfg_data[12:0];
                evag_pkg::REG_SPEECH_LIMIT:   speech_limit_reg   <= cfg_data;
                evag_pkg::REG_SILENCE_LIMIT:  silence_limit_reg  <= cfg_data;
                evag_pkg::REG_MINIMUM_LENGTH: minimum_length_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign back_cfg.packet_loud_minimum = loud_minimum_reg;
    assign back_cfg.speech_limit        = speech_limit_reg;
    assign back_cfg.silence_limit       = silence_limit_reg;
    assign back_cfg.minimum_length      = minimum_length_reg;

    // front: magnitude compare and per-packet counting
    evag_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .quiet_level(quiet_level_reg),
        .sample     (sample),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    // short queue of packet summaries
    evag_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .pop_data (pop_data),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    // back: running totals, flags, decision and the output register
    evag_back #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (back_cfg),
        .queue_empty(queue_empty),
        .pop_data   (pop_data),
        .pop        (pop),
        .result     (result)
    );

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

// bench for the energy voice activity gate
// audio bytes go in as sample beats, one verdict beat comes back per packet end not dropped
module tb;
    import evag_pkg::*;

    localparam int CLK_HALF_NS     = 4;
    localparam int RESET_CYCLES    = 7;
    // extra settle time once every verdict has been taken
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_BEATS    = 700;
    localparam int PHASE_BEATS     = 140;
    localparam longint WATCHDOG_NS = 64'd6_000_000;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_FIRST_UNUSED = REG_MINIMUM_LENGTH + 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_LAST_UNUSED  = '1;
    localparam logic [LIMIT_WIDTH-1:0]   TOTAL_MAX        = '1;

    typedef logic [LIMIT_WIDTH-1:0] total_t;

    typedef enum {STYLE_QUIET, STYLE_LOUD, STYLE_NOISE} byte_style_t;

    typedef struct {
        logic [7:0]           quiet_level;
        logic [PKT_WIDTH-1:0] loud_minimum;
        total_t               speech_limit;
        total_t               silence_limit;
        total_t               minimum_length;
    } gate_settings_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_write_en;
    logic [CFG_IDX_WIDTH-1:0] cfg_index;
    logic [LIMIT_WIDTH-1:0]   cfg_data;

    evag_stream_if #(.payload_t(sample_t)) sample_ch ();
    evag_stream_if #(.payload_t(result_t)) result_ch ();

    energy_voice_activity_gate DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (sample_ch),
        .result       (result_ch)
    );

    always #CLK_HALF_NS clk = ~clk;

    // ------------------------------------------------------------------
    // gate predictor: register copies and detection state
    // ------------------------------------------------------------------
    logic [7:0]           quiet_level_cfg;
    logic [PKT_WIDTH-1:0] loud_minimum_cfg;
    total_t               speech_limit_cfg;
    total_t               silence_limit_cfg;
    total_t               minimum_length_cfg;

    logic [PKT_WIDTH-1:0]     bytes_quiet;
    logic [PKT_WIDTH-1:0]     bytes_loud;
    total_t                   loud_sum;
    total_t                   silence_sum;
    total_t                   utterance_len;
    logic                     in_break;
    logic                     speech_found;
    logic [REQ_NUM_WIDTH-1:0] next_request;

    // verdicts predicted but not yet seen on the result channel
    result_t expected_verdicts[$];

    int   error_count = 0;
    int   beats_sent  = 0;
    // sender runs back to back when set (local to the stimulus process)
    logic steady_flow = 1'b0;
    // these two are written with nonblocking assigns from the stimulus side
    logic steady_sink    = 1'b0;
    logic hold_off_armed = 1'b0;

    function automatic total_t sat_total(input total_t acc, input total_t add);
        logic [LIMIT_WIDTH:0] sum;
        sum = {1'b0, acc} + {1'b0, add};
        return sum[LIMIT_WIDTH] ? TOTAL_MAX : sum[LIMIT_WIDTH-1:0];
    endfunction

    // advance the gate by one accepted byte; a packet end that is not dropped
    // queues exactly one verdict
    function automatic void predict_gate_beat(input sample_t beat);
        logic [8:0]           mag;
        logic [PKT_WIDTH-1:0] quiet;
        logic [PKT_WIDTH-1:0] loud;
        result_t              verdict;
        // -128 has magnitude 128, hence the 9 bit width
        mag = beat.sample_byte[7] ? 9'd256 - {1'b0, beat.sample_byte}
                                  : {1'b0, beat.sample_byte};
        if (mag < {1'b0, quiet_level_cfg})
        begin
            if (bytes_quiet != PKT_MAX) bytes_quiet++;
        end
        else if (bytes_loud != PKT_MAX)
        begin
            bytes_loud++;
        end
        if (!beat.last_in_packet) return;

        quiet       = bytes_quiet;
        loud        = bytes_loud;
        bytes_quiet = '0;
        bytes_loud  = '0;
        // playback on the last byte throws the packet away silently
        if (beat.playback_active) return;

        verdict          = '0;
        verdict.decision = DEC_NONE;
        if (loud > loud_minimum_cfg)
        begin
            loud_sum            = sat_total(loud_sum, total_t'(loud));
            in_break            = 1'b0;
            verdict.keep_packet = 1'b1;
            if (loud_sum > speech_limit_cfg)
            begin
                silence_sum  = '0;
                speech_found = 1'b1;
            end
        end
        else
        begin
            silence_sum = sat_total(silence_sum, total_t'(quiet));
            if (silence_sum > silence_limit_cfg)
            begin
                loud_sum = '0;
                in_break = 1'b1;
            end
        end
        if (verdict.keep_packet)
            utterance_len = sat_total(utterance_len, total_t'(quiet) + total_t'(loud));

        // break after speech: either issue a request or call it too short
        if (in_break && speech_found)
        begin
            if (utterance_len < minimum_length_cfg)
            begin
                verdict.decision = DEC_TOO_SHORT;
            end
            else
            begin
                verdict.decision       = DEC_REQUEST;
                verdict.request_number = next_request;
                verdict.request_length = utterance_len;
                next_request++;
                utterance_len = '0;
                speech_found  = 1'b0;
            end
            in_break    = 1'b0;
            loud_sum    = '0;
            silence_sum = '0;
        end
        expected_verdicts.push_back(verdict);
    endfunction

    // ------------------------------------------------------------------
    // verdict checking at the rising edge
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : verdict_check
        result_t seen;
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            seen = result_ch.payload;
            if (expected_verdicts.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected verdict beat, expected none, got keep %0d dec %0d",
                         $time, seen.keep_packet, seen.decision);
            end
            else
            begin
                want = expected_verdicts.pop_front();
                check_field("keep_packet", want.keep_packet, seen.keep_packet);
                check_field("decision", want.decision, seen.decision);
                check_field("request_number", want.request_number, seen.request_number);
                check_field("request_length", want.request_length, seen.request_length);
            end
        end
    end

    // ------------------------------------------------------------------
    // idle gaps: mostly none or short, now and then a long one
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
        if ($urandom_range(0, 3) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // result side: random stalls, steady stretches and one long hold-off
    initial
    begin : verdict_sink
        int stall;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_armed)
            begin
                // long hold-off so the packet queue fills and sample.ready drops
                hold_off_armed  <= 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
            end
            else if (steady_sink)
            begin
                result_ch.ready <= 1'b1;
            end
            else
            begin
                stall = pick_gap();
                if (stall == 0)
                begin
                    result_ch.ready <= 1'b1;
                end
                else
                begin
                    result_ch.ready <= 1'b0;
                    repeat (stall - 1) @(negedge clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers, all entered and left at a falling edge
    // ------------------------------------------------------------------

    // one sample beat; valid stays high on return so back to back beats
    // need no reassignment
    task automatic send_beat(input sample_t beat);
        int gap;
        gap = steady_flow ? 0 : pick_gap();
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.payload <= beat;
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
        predict_gate_beat(beat);
        beats_sent++;
        @(negedge clk);
    endtask

    // park the sender until every verdict is in, then let the back unit settle
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic drive_register(input logic [CFG_IDX_WIDTH-1:0] idx,
                                  input total_t data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(negedge clk);
        case (idx)
            REG_QUIET_LEVEL:    quiet_level_cfg    = data[7:0];
            REG_LOUD_MINIMUM:   loud_minimum_cfg   = data[PKT_WIDTH-1:0];
            REG_SPEECH_LIMIT:   speech_limit_cfg   = data;
            REG_SILENCE_LIMIT:  silence_limit_cfg  = data;
            REG_MINIMUM_LENGTH: minimum_length_cfg = data;
            default: ;  // unused index, the gate ignores it
        endcase
    endtask

    // only called with the gate idle and no packet half sent
    task automatic load_settings(input gate_settings_t s);
        logic [CFG_IDX_WIDTH-1:0] spare;
        wait_drained();
        spare = CFG_IDX_WIDTH'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED));
        drive_register(REG_QUIET_LEVEL, total_t'(s.quiet_level));
        drive_register(REG_LOUD_MINIMUM, total_t'(s.loud_minimum));
        drive_register(REG_SPEECH_LIMIT, s.speech_limit);
        drive_register(REG_SILENCE_LIMIT, s.silence_limit);
        drive_register(REG_MINIMUM_LENGTH, s.minimum_length);
        // a write to an unused index must change nothing
        drive_register(spare, total_t'($urandom));
        cfg_write_en <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte(input byte_style_t style);
        int         mag;
        logic [7:0] value;
        case (style)
            STYLE_QUIET:
            begin
                if (quiet_level_cfg == 0) return 8'($urandom);
                mag = $urandom_range(0, quiet_level_cfg - 1);
            end
            STYLE_LOUD: mag = $urandom_range(quiet_level_cfg, 128);
            default: return 8'($urandom);
        endcase
        // magnitude 128 maps to -128 either way
        value = 8'(mag);
        if ($urandom_range(0, 1) == 1) value = -value;
        return value;
    endfunction

    function automatic byte_style_t noisy(input byte_style_t style);
        return ($urandom_range(0, 5) == 0) ? STYLE_NOISE : style;
    endfunction

    // mostly short packets, a few longer ones
    function automatic int pick_length();
        if ($urandom_range(0, 19) == 0) return $urandom_range(40, 200);
        return $urandom_range(1, 24);
    endfunction

    task automatic send_random_packet(input byte_style_t style, input int length);
        sample_t beat;
        logic    drop;
        drop = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < length; i++)
        begin
            beat.sample_byte    = pick_byte(style);
            beat.last_in_packet = (i == length - 1);
            // playback only counts on the last byte, elsewhere it is noise
            beat.playback_active = beat.last_in_packet ? drop : ($urandom_range(0, 3) == 0);
            send_beat(beat);
        end
    endtask

    task automatic send_listed(input logic [7:0] bytes[$], input logic drop,
                               input logic playback_rest);
        sample_t beat;
        for (int i = 0; i < bytes.size(); i++)
        begin
            beat.sample_byte     = bytes[i];
            beat.last_in_packet  = (i == bytes.size() - 1);
            beat.playback_active = beat.last_in_packet ? drop : playback_rest;
            send_beat(beat);
        end
    endtask

    // talk bursts followed by pauses: builds up speech and then a break,
    // so requests and too-short verdicts come up regularly
    task automatic run_sessions(input int budget);
        int first;
        first = beats_sent;
        while (beats_sent - first < budget)
        begin
            repeat ($urandom_range(1, 5))
                send_random_packet(noisy(STYLE_LOUD), pick_length());
            repeat ($urandom_range(1, 5))
                send_random_packet(noisy(STYLE_QUIET), pick_length());
        end
    endtask

    function automatic gate_settings_t random_settings();
        gate_settings_t s;
        s.quiet_level    = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 128));
        s.loud_minimum   = PKT_WIDTH'($urandom_range(0, 8));
        s.speech_limit   = total_t'($urandom_range(0, 80));
        s.silence_limit  = total_t'($urandom_range(0, 60));
        s.minimum_length = total_t'($urandom_range(0, 150));
        return s;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // register defaults straight out of reset
    task automatic test_reset_defaults();
        send_random_packet(STYLE_LOUD, 60);
        send_random_packet(STYLE_QUIET, 20);
        send_random_packet(STYLE_NOISE, 30);
        send_random_packet(STYLE_LOUD, 55);
    endtask

    task automatic test_directed_cases();
        gate_settings_t s;
        logic [7:0]     bytes[$];
        s = '{quiet_level: 8'd10, loud_minimum: 13'd2, speech_limit: 24'd3,
              silence_limit: 24'd3, minimum_length: 24'd8};
        load_settings(s);
        // -128, 127 and magnitude exactly at the quiet level are all loud
        bytes = '{8'h80, 8'h7f, 8'h0a, 8'hf6};
        send_listed(bytes, 1'b0, 1'b0);
        // just under the level is quiet: break after speech, too short
        bytes = '{8'h09, 8'hf7, 8'h00, 8'hff, 8'h05};
        send_listed(bytes, 1'b0, 1'b0);
        // playback on the last byte drops the packet
        bytes = '{8'h64, 8'h64, 8'h64};
        send_listed(bytes, 1'b1, 1'b0);
        // playback on earlier bytes does nothing
        bytes = '{8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f};
        send_listed(bytes, 1'b0, 1'b1);
        // silence now ends a long enough utterance: request issued
        bytes = '{8'h00, 8'h00, 8'h00, 8'h00};
        send_listed(bytes, 1'b0, 1'b0);
        // single byte packet, too few loud bytes to keep
        bytes = '{8'h80};
        send_listed(bytes, 1'b0, 1'b0);
    endtask

    task automatic test_random_sessions();
        int first;
        first = beats_sent;
        while (beats_sent - first < RANDOM_BEATS)
        begin
            load_settings(random_settings());
            steady_flow = ($urandom_range(0, 3) == 0);
            steady_sink <= ($urandom_range(0, 3) == 0);
            run_sessions(PHASE_BEATS);
        end
        steady_flow = 1'b0;
        steady_sink <= 1'b0;
    endtask

    // sink holds off while the sender keeps pushing short packets
    task automatic test_backpressure();
        load_settings(random_settings());
        hold_off_armed <= 1'b1;
        steady_flow = 1'b1;
        repeat (40) send_random_packet(noisy(STYLE_LOUD), $urandom_range(1, 3));
        steady_flow = 1'b0;
    endtask

    task automatic test_extreme_settings();
        gate_settings_t s;
        // everything but -128 is quiet, every limit at zero
        s = '{quiet_level: 8'd128, loud_minimum: '0, speech_limit: '0,
              silence_limit: '0, minimum_length: '0};
        load_settings(s);
        run_sessions(80);
        // nothing is quiet, every total limit at its top, loud minimum at 4096
        s = '{quiet_level: 8'd0, loud_minimum: 13'd4096, speech_limit: TOTAL_MAX,
              silence_limit: TOTAL_MAX, minimum_length: TOTAL_MAX};
        load_settings(s);
        run_sessions(60);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        cfg_write_en      = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        sample_ch.valid   = 1'b0;
        sample_ch.payload = '0;

        // predictor in its reset state
        quiet_level_cfg    = QUIET_LEVEL_RST;
        loud_minimum_cfg   = LOUD_MINIMUM_RST;
        speech_limit_cfg   = SPEECH_LIMIT_RST;
        silence_limit_cfg  = SILENCE_LIMIT_RST;
        minimum_length_cfg = MINIMUM_LENGTH_RST;
        bytes_quiet        = '0;
        bytes_loud         = '0;
        loud_sum           = '0;
        silence_sum        = '0;
        utterance_len      = '0;
        in_break           = 1'b0;
        speech_found       = 1'b0;
        next_request       = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_directed_cases();
        test_random_sessions();
        test_backpressure();
        test_extreme_settings();

        wait_drained();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // hung handshake guard
    initial
    begin
        #(WATCHDOG_NS);
        $display("%0t: timeout, %0d verdicts outstanding", $time, expected_verdicts.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
